/* src/edd_pkg.sv */
// Shared types, widths and helpers for the error-diffusion dither block.
// Used by edd_recip, edd_lane and error_diffusion_dither. No dependencies.
package edd_pkg;

    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam int NUM_CHAN          = 3;

    localparam int SAMPLE_W   = 8;
    localparam int FRAC_W     = 8;
    localparam int IW_W       = 12;
    localparam int LC_W       = 9;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int IW_RESET   = 640;

    localparam int STEPS_W   = 8;
    localparam int STEPS_MAX = 255;
    localparam int LC_MAX    = 256;

    localparam int ST_W        = 18;
    localparam int SUM_W       = ST_W + 2;
    localparam int SH_W        = ST_W + 3;
    localparam int XV_W        = 20;
    localparam int MAG_W       = XV_W - 1;
    localparam int N1_W        = MAG_W + STEPS_W;
    localparam int B_W         = N1_W - FRAC_W;
    localparam int Q_W         = 11;
    localparam int N2_W        = 27;
    localparam int RECIP_W     = 36;
    localparam int RECIP_SHIFT = 35;
    localparam int HALF_W      = RECIP_W / 2;
    localparam int PP_W        = N2_W + HALF_W;
    localparam int FULL_W      = PP_W + HALF_W;
    localparam int Y_W         = FULL_W - RECIP_SHIFT;

    localparam int SCALE_Q8     = 65280;
    localparam int HALF_SCALE   = 32640;
    localparam int LEVEL_MAX    = 255;
    localparam int INV255_MUL   = 257;
    localparam int INV255_SHIFT = 16;
    localparam int SHARE_HALF   = 8;
    localparam int SHARE_SHIFT  = 4;
    localparam int OUT_HALF     = 128;

    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(2 ** (ST_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_HI - SUM_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH = 2'd0,
        REG_LEVEL_COUNT = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_SCALE,
        ST_RECIP,
        ST_QUANT,
        ST_SHARE,
        ST_COMMIT,
        ST_TAIL
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic commit;
        logic last;
        logic use_mem;
    } lane_ctrl_t;

    function automatic logic signed [ST_W-1:0] sat_store(input logic signed [SUM_W-1:0] v);
        logic signed [ST_W-1:0] res;
        if (v > SUM_HI)
            res = ST_W'(SUM_HI);
        else if (v < SUM_LO)
            res = ST_W'(SUM_LO);
        else
            res = ST_W'(v);
        return res;
    endfunction

    // divide by 16, rounding half away from zero
    function automatic logic signed [ST_W-1:0] round_div16(input logic signed [SH_W-1:0] v);
        logic [SH_W-1:0]        mag;
        logic [SH_W-1:0]        rnd;
        logic signed [ST_W-1:0] res;
        mag = v[SH_W-1] ? SH_W'(-v) : SH_W'(v);
        rnd = (mag + SH_W'(SHARE_HALF)) >> SHARE_SHIFT;
        res = ST_W'(rnd);
        return v[SH_W-1] ? -res : res;
    endfunction

endpackage

/* src/edd_recip.sv */
// Reciprocal unit: ceil(2^35 / steps) by restoring division, one bit per cycle.
// Depends on edd_pkg.
module edd_recip (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [edd_pkg::STEPS_W-1:0]   divisor,
    output logic                          busy,
    output logic [edd_pkg::RECIP_W-1:0]   recip
);
    import edd_pkg::*;

    localparam int CNT_W = $clog2(RECIP_W + 1);

    logic               busy_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [STEPS_W-1:0] rem_reg;
    logic [RECIP_W-1:0] quo_reg;
    logic [STEPS_W-1:0] div_reg;
    logic [RECIP_W-1:0] recip_reg;

    logic [STEPS_W:0]   trial;
    logic               ge;
    logic [STEPS_W-1:0] rem_next;
    logic [RECIP_W-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[RECIP_W-1]};
        ge       = trial >= {1'b0, div_reg};
        rem_next = ge ? STEPS_W'(trial - {1'b0, div_reg}) : trial[STEPS_W-1:0];
        quo_next = {quo_reg[RECIP_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            recip_reg <= RECIP_W'(1) << RECIP_SHIFT;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(RECIP_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg  <= 1'b0;
                recip_reg <= quo_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            // dividend 2^35 + d - 1 gives the ceiling
            quo_reg <= (RECIP_W'(1) << RECIP_SHIFT) + RECIP_W'(divisor) - RECIP_W'(1);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy  = busy_reg;
    assign recip = recip_reg;

endmodule

/* src/edd_lane.sv */
// One channel's quantize and diffuse datapath, stepped by the top-level sequencer.
// Holds the right carry and below partial sums. Depends on edd_pkg.
module edd_lane (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  edd_pkg::lane_ctrl_t                  ctrl,
    input  logic [edd_pkg::SAMPLE_W-1:0]         sample,
    input  logic [edd_pkg::STEPS_W-1:0]          steps,
    input  logic [edd_pkg::RECIP_W-1:0]          recip,
    input  logic signed [edd_pkg::ST_W-1:0]      line_err,
    output logic [edd_pkg::SAMPLE_W-1:0]         level,
    output logic signed [edd_pkg::ST_W-1:0]      left_err,
    output logic signed [edd_pkg::ST_W-1:0]      tail_err
);
    import edd_pkg::*;

    logic [SAMPLE_W-1:0]    sample_reg;
    logic signed [ST_W-1:0] rc_reg;
    logic signed [ST_W-1:0] bp0_reg;
    logic signed [ST_W-1:0] bp1_reg;

    logic signed [XV_W-1:0] xv_reg;
    logic [N1_W-1:0]        n1_reg;
    logic [B_W-1:0]         b_reg;
    logic [Q_W-1:0]         q0_reg;
    logic [Q_W-1:0]         qa_reg;
    logic [N2_W-1:0]        n2_reg;
    logic [PP_W-1:0]        pl_reg;
    logic [PP_W-1:0]        ph_reg;
    logic signed [Y_W-1:0]  y_reg;
    logic signed [ST_W-1:0] e_reg;

    logic signed [XV_W-1:0] xv_sum;
    logic [MAG_W-1:0]       xv_mag;
    logic [N1_W-1:0]        n1_next;
    logic [N1_W-1:0]        b_full;
    logic [B_W-1:0]         b_next;
    logic [N1_W-1:0]        b_x257;
    logic [Q_W-1:0]         q0_next;
    logic [B_W-1:0]         q0_x255;
    logic [Q_W-1:0]         qa_next;
    logic [N2_W-1:0]        n2_next;
    logic [PP_W-1:0]        pl_next;
    logic [PP_W-1:0]        ph_next;
    logic [FULL_W-1:0]      full;
    logic [Y_W-1:0]         y_mag;
    logic signed [Y_W-1:0]  y_next;
    logic signed [Y_W-1:0]  e_wide;

    logic signed [SH_W-1:0] e_ext;
    logic signed [ST_W-1:0] s7;
    logic signed [ST_W-1:0] s5;
    logic signed [ST_W-1:0] s3;
    logic signed [ST_W-1:0] s1;
    logic [Y_W-1:0]         y_rnd;

    // X and |X| * steps
    always_comb
    begin
        xv_sum = signed'(XV_W'({sample_reg, FRAC_W'(0)})) + XV_W'(rc_reg)
               + (ctrl.use_mem ? XV_W'(line_err) : XV_W'(0));
        xv_mag  = MAG_W'(xv_sum[XV_W-1] ? -xv_sum : xv_sum);
        n1_next = N1_W'(xv_mag * steps);
    end

    // level index: round(n1 / 65280), via /256 then /255 with one correction
    always_comb
    begin
        b_full  = n1_reg + N1_W'(HALF_SCALE);
        b_next  = B_W'(b_full >> FRAC_W);
        b_x257  = N1_W'(b_reg) * N1_W'(INV255_MUL);
        q0_next = Q_W'(b_x257 >> INV255_SHIFT);
        q0_x255 = (B_W'(q0_reg) << FRAC_W) - B_W'(q0_reg);
        qa_next = ((b_reg - q0_x255) >= B_W'(LEVEL_MAX)) ? q0_reg + Q_W'(1) : q0_reg;
    end

    // level value: round(q * 65280 / steps) by the stored reciprocal
    always_comb
    begin
        n2_next = N2_W'(qa_reg) * N2_W'(SCALE_Q8) + N2_W'(steps >> 1);
        pl_next = PP_W'(n2_reg) * PP_W'(recip[HALF_W-1:0]);
        ph_next = PP_W'(n2_reg) * PP_W'(recip[RECIP_W-1:HALF_W]);
        full    = (FULL_W'(ph_reg) << HALF_W) + FULL_W'(pl_reg);
        y_mag   = full[FULL_W-1:RECIP_SHIFT];
        y_next  = xv_reg[XV_W-1] ? -signed'(y_mag) : signed'(y_mag);
        e_wide  = Y_W'(xv_reg) - y_next;
    end

    // error shares and output level
    always_comb
    begin
        e_ext    = SH_W'(e_reg);
        s7       = round_div16((e_ext <<< 3) - e_ext);
        s5       = round_div16((e_ext <<< 2) + e_ext);
        s3       = round_div16((e_ext <<< 1) + e_ext);
        s1       = round_div16(e_ext);
        left_err = sat_store(SUM_W'(bp0_reg) + SUM_W'(s3));
        tail_err = sat_store(SUM_W'(bp1_reg) + SUM_W'(s5));
        y_rnd    = (Y_W'(y_reg) + Y_W'(OUT_HALF)) >> FRAC_W;
        if (y_reg[Y_W-1])
            level = '0;
        else if (y_rnd > Y_W'(LEVEL_MAX))
            level = SAMPLE_W'(LEVEL_MAX);
        else
            level = y_rnd[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            sample_reg <= sample;
        xv_reg <= xv_sum;
        n1_reg <= n1_next;
        b_reg  <= b_next;
        q0_reg <= q0_next;
        qa_reg <= qa_next;
        n2_reg <= n2_next;
        pl_reg <= pl_next;
        ph_reg <= ph_next;
        y_reg  <= y_next;
        e_reg  <= ST_W'(e_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg  <= '0;
            bp0_reg <= '0;
            bp1_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            rc_reg  <= '0;
            bp0_reg <= '0;
            bp1_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            rc_reg  <= ctrl.last ? '0 : s7;
            bp0_reg <= ctrl.last ? '0 : tail_err;
            bp1_reg <= ctrl.last ? '0 : s1;
        end
    end

endmodule

/* src/error_diffusion_dither.sv */
// Floyd-Steinberg dither, three channels, line store of one row per channel.
// Each pixel steps MUL, DIV, FIX, SCALE, RECIP, QUANT, SHARE, COMMIT; COMMIT waits on output stall,
// new input is taken only in IDLE, and a row's last pixel adds TAIL (second line-store write).
// A level_count write runs the reciprocal divider; input and config stall meanwhile.
// Reset: 640-pixel width, 2 levels, first row; the line store is covered by a fill count.
module error_diffusion_dither #(
    parameter int MAX_WIDTH = edd_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [edd_pkg::SAMPLE_W-1:0]      chan0_in,
    input  logic [edd_pkg::SAMPLE_W-1:0]      chan1_in,
    input  logic [edd_pkg::SAMPLE_W-1:0]      chan2_in,
    input  logic                              frame_start,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [edd_pkg::SAMPLE_W-1:0]      chan0_out,
    output logic [edd_pkg::SAMPLE_W-1:0]      chan1_out,
    output logic [edd_pkg::SAMPLE_W-1:0]      chan2_out,
    output logic                              row_end,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [edd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import edd_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int WC_W  = (CNT_W > IW_W) ? CNT_W : IW_W;
    localparam int ROW_W = NUM_CHAN * ST_W;

    state_t state_reg;
    state_t state_next;

    logic [IW_W-1:0]    image_width_reg;
    logic [STEPS_W-1:0] steps_reg;
    logic [COL_W-1:0]   col_reg;
    logic               first_row_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [COL_W-1:0]   x_reg;
    logic               first_reg;
    logic               last_reg;
    logic               use_mem_reg;
    logic               out_valid_reg;
    logic [SAMPLE_W-1:0] level_out_reg [NUM_CHAN];
    logic               row_end_reg;
    logic [ROW_W-1:0]   tail_row_reg;
    logic [ROW_W-1:0]   rd_row_reg;

    logic [ROW_W-1:0]   line_mem [MAX_WIDTH];

    logic               in_fire;
    logic               cfg_fire;
    logic               out_free;
    logic               commit_fire;
    logic               wr_tail;
    logic               wr_en;
    logic [COL_W-1:0]   wr_addr;
    logic [ROW_W-1:0]   wr_row;
    logic [ROW_W-1:0]   left_row;
    logic [ROW_W-1:0]   tail_row;

    logic [COL_W-1:0]   x_acc;
    logic               first_acc;
    logic [WC_W-1:0]    w_eff;
    logic               last_acc;
    logic [LC_W-1:0]    lc_cfg;
    logic [STEPS_W-1:0] steps_cfg;
    logic               recip_start;
    logic               recip_busy;
    logic [RECIP_W-1:0] recip;
    lane_ctrl_t         lane_ctrl;

    logic [SAMPLE_W-1:0]    sample_in [NUM_CHAN];
    logic [SAMPLE_W-1:0]    level [NUM_CHAN];
    logic signed [ST_W-1:0] left_err [NUM_CHAN];
    logic signed [ST_W-1:0] tail_err [NUM_CHAN];

    assign sample_in[0] = chan0_in;
    assign sample_in[1] = chan1_in;
    assign sample_in[2] = chan2_in;

    // configuration
    assign cfg_ready   = !recip_busy;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign lc_cfg      = cfg_data[LC_W-1:0];
    assign recip_start = cfg_fire && (cfg_index == REG_LEVEL_COUNT);

    always_comb
    begin
        if (lc_cfg < LC_W'(2))
            steps_cfg = STEPS_W'(1);
        else if (lc_cfg > LC_W'(LC_MAX))
            steps_cfg = STEPS_W'(STEPS_MAX);
        else
            steps_cfg = STEPS_W'(lc_cfg - LC_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IW_W'(IW_RESET);
            steps_reg       <= STEPS_W'(1);
        end
        else if (cfg_fire)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH: image_width_reg <= cfg_data[IW_W-1:0];
                REG_LEVEL_COUNT: steps_reg       <= steps_cfg;
                default: ;
            endcase
        end
    end

    edd_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (recip_start),
        .divisor (steps_cfg),
        .busy    (recip_busy),
        .recip   (recip)
    );

    // position of the incoming pixel
    always_comb
    begin
        x_acc     = frame_start ? '0 : col_reg;
        first_acc = frame_start || first_row_reg;
        if (image_width_reg == '0)
            w_eff = WC_W'(1);
        else if (WC_W'(image_width_reg) > WC_W'(MAX_WIDTH))
            w_eff = WC_W'(MAX_WIDTH);
        else
            w_eff = WC_W'(image_width_reg);
        last_acc = (WC_W'(x_acc) + WC_W'(1)) >= w_eff;
    end

    // sequencer
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_MUL;
            ST_MUL:    state_next = ST_DIV;
            ST_DIV:    state_next = ST_FIX;
            ST_FIX:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_RECIP;
            ST_RECIP:  state_next = ST_QUANT;
            ST_QUANT:  state_next = ST_SHARE;
            ST_SHARE:  state_next = ST_COMMIT;
            ST_COMMIT: if (out_free) state_next = last_reg ? ST_TAIL : ST_IDLE;
            ST_TAIL:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        commit_fire = 1'b0;
        wr_tail     = 1'b0;
        case (state_reg)
            ST_IDLE:   in_stall    = recip_busy;
            ST_COMMIT: commit_fire = out_free;
            ST_TAIL:   wr_tail     = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            x_reg         <= '0;
            first_reg     <= 1'b1;
            last_reg      <= 1'b0;
            use_mem_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            x_reg       <= x_acc;
            first_reg   <= first_acc;
            last_reg    <= last_acc;
            use_mem_reg <= !first_acc && (CNT_W'(x_acc) < fill_reg);
        end
        else if (commit_fire)
        begin
            col_reg       <= last_reg ? '0 : x_reg + COL_W'(1);
            first_row_reg <= last_reg ? 1'b0 : first_reg;
        end
    end

    assign lane_ctrl.load    = in_fire;
    assign lane_ctrl.clear   = in_fire && frame_start;
    assign lane_ctrl.commit  = commit_fire;
    assign lane_ctrl.last    = last_reg;
    assign lane_ctrl.use_mem = use_mem_reg;

    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_lane
        edd_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .sample   (sample_in[c]),
            .steps    (steps_reg),
            .recip    (recip),
            .line_err (signed'(rd_row_reg[c*ST_W +: ST_W])),
            .level    (level[c]),
            .left_err (left_err[c]),
            .tail_err (tail_err[c])
        );
        assign left_row[c*ST_W +: ST_W] = left_err[c];
        assign tail_row[c*ST_W +: ST_W] = tail_err[c];
    end

    // line store: read at transfer, write left column at commit, own column at row end
    assign wr_en   = (commit_fire && (x_reg != '0)) || wr_tail;
    assign wr_addr = wr_tail ? x_reg : x_reg - COL_W'(1);
    assign wr_row  = wr_tail ? tail_row_reg : left_row;

    always_ff @(posedge clk)
    begin
        if (in_fire)
            rd_row_reg <= line_mem[x_acc];
        if (wr_en)
            line_mem[wr_addr] <= wr_row;
    end

    // columns below fill_reg hold written data; the rest read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (wr_en && ((CNT_W'(wr_addr) + CNT_W'(1)) > fill_reg))
            fill_reg <= CNT_W'(wr_addr) + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (commit_fire)
        begin
            tail_row_reg <= tail_row;
            row_end_reg  <= last_reg;
            for (int c = 0; c < NUM_CHAN; c++)
                level_out_reg[c] <= level[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign chan0_out = level_out_reg[0];
    assign chan1_out = level_out_reg[1];
    assign chan2_out = level_out_reg[2];
    assign row_end   = row_end_reg;

endmodule

/* tb/sv/error_diffusion_dither_tb.sv */
// Self-checking testbench for error_diffusion_dither: directed table, then random frames
// under three idle/stall mixes and a row start at the widest setting, checked against a local predictor.
// Depends on edd_pkg and error_diffusion_dither only.
module error_diffusion_dither_tb;
    import edd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_W     = DEFAULT_MAX_WIDTH;
    localparam longint STORE_HI  = (longint'(1) <<< (ST_W - 1)) - 1;
    localparam longint STORE_LO  = -STORE_HI - 1;
    localparam int     SUB_RUNS  = 5;
    localparam int     SUB_ITEMS = 40;
    localparam int     WIDE_ITEMS = 130;
    localparam logic   PIX = 1'b0;
    localparam logic   CFG = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] c0;
        logic [SAMPLE_W-1:0] c1;
        logic [SAMPLE_W-1:0] c2;
        logic                first;
    } pixel_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] c0;
        logic [SAMPLE_W-1:0] c1;
        logic [SAMPLE_W-1:0] c2;
        logic                last;
    } dither_out_t;

    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]   c0;
        logic [SAMPLE_W-1:0]   c1;
        logic [SAMPLE_W-1:0]   c2;
        logic                  first;
        logic                  typed;
        logic [SAMPLE_W-1:0]   w0;
        logic [SAMPLE_W-1:0]   w1;
        logic [SAMPLE_W-1:0]   w2;
        logic                  w_end;
    } step_t;

    localparam int PLAN_LEN = 27;
    localparam step_t PLAN [PLAN_LEN] = '{
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1,
          8'd255, 8'd255, 8'd255, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b1,
          8'd0, 8'd255, 8'd0, 1'b0},
        '{CFG, REG_IMAGE_WIDTH, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd128, 8'd127, 8'd1, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd200, 8'd50, 8'd255, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd100, 8'd100, 8'd100, 1'b1, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{CFG, REG_LEVEL_COUNT, 12'd1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{CFG, REG_IMAGE_WIDTH, 12'd3, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd127, 8'd128, 8'd129, 1'b1, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd64, 8'd192, 8'd32, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd255, 8'd0, 8'd255, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd10, 8'd245, 8'd128, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{CFG, REG_LEVEL_COUNT, 12'd256, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd1, 8'd254, 8'd127, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd128, 8'd128, 8'd128, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{CFG, REG_LEVEL_COUNT, 12'hFFF, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd255, 8'd0, 8'd77, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{CFG, REG_LEVEL_COUNT, 12'd3, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{CFG, REG_UNMAPPED, 12'hFFF, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd85, 8'd170, 8'd43, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd0, 8'd255, 8'd128, 1'b1, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd191, 8'd64, 8'd250, 1'b0, 1'b0,
          8'd0, 8'd0, 8'd0, 1'b0},
        '{CFG, REG_IMAGE_WIDTH, 12'd2, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0},
        '{PIX, REG_IMAGE_WIDTH, 12'd0, 8'd254, 8'd1, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0}
    };

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   chan0_in    = '0;
    logic [SAMPLE_W-1:0]   chan1_in    = '0;
    logic [SAMPLE_W-1:0]   chan2_in    = '0;
    logic                  frame_start = 1'b0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [SAMPLE_W-1:0]   chan0_out;
    logic [SAMPLE_W-1:0]   chan1_out;
    logic [SAMPLE_W-1:0]   chan2_out;
    logic                  row_end;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;

    // predictor state
    int             line_err [MAX_W*NUM_CHAN];
    int             right_err [NUM_CHAN];
    int             below_acc [2*NUM_CHAN];
    int             col_pos    = 0;
    bit             in_top_row = 1'b1;
    logic [IW_W-1:0] width_reg  = IW_W'(IW_RESET);
    logic [LC_W-1:0] levels_reg = LC_W'(2);

    dither_out_t dithered_q [$];
    dither_out_t head_px;

    error_diffusion_dither dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .chan0_in    (chan0_in),
        .chan1_in    (chan1_in),
        .chan2_in    (chan2_in),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .chan0_out   (chan0_out),
        .chan1_out   (chan1_out),
        .chan2_out   (chan2_out),
        .row_end     (row_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic longint rdiv(input longint n, input longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic int clamp18(input longint v);
        if (v > STORE_HI)
            return int'(STORE_HI);
        if (v < STORE_LO)
            return int'(STORE_LO);
        return int'(v);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(19))
            0, 1, 2: return '0;
            3, 4, 5: return '1;
            6:       return SAMPLE_W'(127 + $urandom_range(1));
            default: return SAMPLE_W'($urandom_range(255));
        endcase
    endfunction

    task automatic dither_predict(input pixel_t px, output dither_out_t res);
        int                  w;
        int                  x;
        int                  here;
        longint              steps;
        longint              xv;
        longint              q;
        longint              y;
        longint              e;
        longint              o;
        bit                  last;
        logic [SAMPLE_W-1:0] smp [NUM_CHAN];
        logic [SAMPLE_W-1:0] lvl [NUM_CHAN];

        w = int'(width_reg);
        if (w < 1)
            w = 1;
        if (w > MAX_W)
            w = MAX_W;
        steps = longint'(levels_reg) - 1;
        if (steps < 1)
            steps = 1;
        if (steps > STEPS_MAX)
            steps = STEPS_MAX;

        if (px.first)
        begin
            col_pos    = 0;
            in_top_row = 1'b1;
            foreach (right_err[c])
                right_err[c] = 0;
            foreach (below_acc[c])
                below_acc[c] = 0;
        end

        x    = col_pos % MAX_W;
        last = (x + 1 >= w);
        smp[0] = px.c0;
        smp[1] = px.c1;
        smp[2] = px.c2;

        for (int c = 0; c < NUM_CHAN; c++)
        begin
            here = x * NUM_CHAN + c;
            xv   = longint'(smp[c]) * 256 + right_err[c];
            if (!in_top_row)
                xv += line_err[here];
            q = rdiv(xv * steps, SCALE_Q8);
            y = rdiv(q * SCALE_Q8, steps);
            e = xv - y;
            o = rdiv(y, 256);
            if (o < 0)
                o = 0;
            if (o > LEVEL_MAX)
                o = LEVEL_MAX;
            lvl[c] = SAMPLE_W'(o);

            right_err[c] = last ? 0 : clamp18(rdiv(e * 7, 16));
            if (x > 0)
                line_err[(x - 1) * NUM_CHAN + c] =
                    clamp18(longint'(below_acc[2*c]) + rdiv(e * 3, 16));
            below_acc[2*c]   = clamp18(longint'(below_acc[2*c+1]) + rdiv(e * 5, 16));
            below_acc[2*c+1] = last ? 0 : clamp18(rdiv(e, 16));
            if (last)
            begin
                line_err[here]   = below_acc[2*c];
                below_acc[2*c]   = 0;
                below_acc[2*c+1] = 0;
            end
        end

        res.c0   = lvl[0];
        res.c1   = lvl[1];
        res.c2   = lvl[2];
        res.last = last;
        if (last)
        begin
            col_pos    = 0;
            in_top_row = 1'b0;
        end
        else
        begin
            col_pos = (x + 1) & 'h7FF;
        end
    endtask

    task automatic push_pixel(input pixel_t px, input bit typed, input dither_out_t want);
        dither_out_t predicted;

        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        chan0_in    <= px.c0;
        chan1_in    <= px.c1;
        chan2_in    <= px.c2;
        frame_start <= px.first;
        do
            @(posedge clk);
        while (in_stall);
        dither_predict(px, predicted);
        dithered_q.push_back(typed ? want : predicted);
    endtask

    // leaves cfg_valid high; the caller drops it after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = value[IW_W-1:0];
        else if (idx == REG_LEVEL_COUNT)
            levels_reg = value[LC_W-1:0];
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (dithered_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (dithered_q.size() == 0)
            begin
                $error("output transfer with no pixel outstanding");
                mismatches++;
            end
            else
            begin
                head_px = dithered_q.pop_front();
                check_field("chan0_out", head_px.c0, chan0_out);
                check_field("chan1_out", head_px.c1, chan1_out);
                check_field("chan2_out", head_px.c2, chan2_out);
                check_field("row_end", head_px.last, row_end);
            end
        end
    end

    initial
    begin
        step_t                 row;
        pixel_t                px;
        dither_out_t           want;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] ldata;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 10;
        recv_idle_pct = 86;
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            row = PLAN[i];
            if (row.is_write)
            begin
                drain();
                write_reg(row.idx, row.data);
                cfg_valid <= 1'b0;
            end
            else
            begin
                px   = '{c0: row.c0, c1: row.c1, c2: row.c2, first: row.first};
                want = '{c0: row.w0, c1: row.w1, c2: row.w2, last: row.w_end};
                push_pixel(px, row.typed, want);
            end
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 10;
                    recv_idle_pct = 86;
                end
                1:
                begin
                    send_idle_pct = 86;
                    recv_idle_pct = 10;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int sub = 0; sub < SUB_RUNS; sub++)
            begin
                case ($urandom_range(9))
                    0:       wdata = '0;
                    1:       wdata = CFG_DATA_W'(1);
                    2:       wdata = CFG_DATA_W'(2);
                    3:       wdata = '1;
                    4:       wdata = CFG_DATA_W'(MAX_W);
                    default: wdata = CFG_DATA_W'($urandom_range(3, 40));
                endcase
                case ($urandom_range(7))
                    0:       ldata = '0;
                    1:       ldata = CFG_DATA_W'(1);
                    2:       ldata = CFG_DATA_W'(2);
                    3:       ldata = CFG_DATA_W'(LC_MAX);
                    4:       ldata = CFG_DATA_W'($urandom_range(257, 511));
                    default: ldata = CFG_DATA_W'($urandom_range(3, 255));
                endcase
                ldata[CFG_DATA_W-1:LC_W] = (CFG_DATA_W-LC_W)'($urandom);
                drain();
                write_reg(REG_IMAGE_WIDTH, wdata);
                write_reg(REG_LEVEL_COUNT, ldata);
                cfg_valid <= 1'b0;
                for (int n = 0; n < SUB_ITEMS; n++)
                begin
                    px.c0    = pick_sample();
                    px.c1    = pick_sample();
                    px.c2    = pick_sample();
                    px.first = (n == 0) ? ($urandom_range(1) == 1) : ($urandom_range(39) == 0);
                    push_pixel(px, 1'b0, '0);
                end
            end
        end

        // start of a row at the widest setting
        drain();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(MAX_W));
        write_reg(REG_LEVEL_COUNT, CFG_DATA_W'($urandom_range(2, LC_MAX)));
        cfg_valid <= 1'b0;
        for (int n = 0; n < WIDE_ITEMS; n++)
        begin
            px.c0    = pick_sample();
            px.c1    = pick_sample();
            px.c2    = pick_sample();
            px.first = (n == 0);
            push_pixel(px, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (dithered_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("[error_diffusion_dither] OK");
        else
            $display("[error_diffusion_dither] ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("[error_diffusion_dither] ERROR");
        $finish;
    end

endmodule
